/* hdl/wsc_pkg.sv */
// ----------------------------------------------------------------------------
// wsc_pkg: shared types and constants of the window sigma clip unit
// Widths of the pixel store, the arithmetic units and the control interface
// between controller and datapath.
// ----------------------------------------------------------------------------
package wsc_pkg;

  // Store geometry.
  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;
  localparam int MAX_HALF = 8;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_W + COL_W;

  // Field widths.
  localparam int PIX_W    = 32;
  localparam int ENTRY_W  = PIX_W + 1;
  localparam int FRAME_W  = 9;
  localparam int HALF_W   = 4;
  localparam int SIGMA_W  = 16;
  localparam int CNT_W    = 9;

  // Arithmetic widths.
  localparam int SUM_W    = 41;
  localparam int SQ_W     = 48;
  localparam int SUMSQ_W  = 57;
  localparam int DIV_W    = 57;
  localparam int ROOT_W   = 37;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int THR_W    = SIGMA_W + ROOT_W;

  // Channel widths.
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_ROWS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_COLS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_SIGMA = 3'd4;

  // Request kinds.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Commands from controller to datapath.
  typedef struct packed {
    logic wr_en;      // store the accepted write request
    logic q_latch;    // latch the accepted query address
    logic centre_rd;  // read the centre entry
    logic scan_load;  // restart the window scanner
    logic clr_acc;    // clear count and sum
    logic scan_rd;    // read the current window entry and advance
    logic pass2;      // window reads belong to the deviation pass
    logic div_start;  // start the divider
    logic div_sel;    // 0: sum by count, 1: squares by count minus one
    logic mean_cap;   // capture the mean
    logic sqrt_start; // start the root on the variance
    logic thr_cap;    // capture the scaled deviation
    logic dec_cap;    // capture the clip decision
    logic res_load;   // load the result register
  } wsc_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic q_in_range; // addressed pixel lies inside the frame
    logic scan_last;  // scanner stands on the last window entry
    logic pipe_busy;  // window reads still in flight
    logic stats_ok;   // at least two valid samples and a valid centre
    logic div_done;
    logic sqrt_done;
    logic slot_free;  // result register can take a new result
  } wsc_sts_t;

endpackage

/* hdl/window_sigma_clip_unit.sv */
// ----------------------------------------------------------------------------
// window_sigma_clip_unit: local sigma clipping over a stored frame
// Stores Q16.16 pixels with valid flags and answers queries with the centre
// pixel, clipped against mean plus a multiple of the window deviation.
//
//   Channel | Direction | Carries
//   in_     | slave     | write or query request, tuser selects the kind
//   out_    | master    | one result per in-frame query
//   cfg_    | write     | frame size, window half sizes, clip factor
//
// A query reads the window twice, one entry a cycle per pass from the single
// memory read port, and the two divides and the root run one bit or digit a
// cycle. With fewer than two valid samples or an invalid centre a query ends
// after the first pass. Reset is synchronous, clears control state and loads
// the configuration defaults; the memory holds no reset value.
// A stalled result sits in the output register while the next request is
// taken; a finished query waits for that register to be free.
// ----------------------------------------------------------------------------
module window_sigma_clip_unit
  import wsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // in_tdata: row[7:0], col[15:8], pixel_value[47:16], pixel_valid[48]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: action[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata: out_value[31:0], out_valid[32], was_clipped[33],
  //            window_count[42:34]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  wsc_cmd_t cmd;
  wsc_sts_t sts;

  // Sequencer.
  wsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Store and arithmetic.
  wsc_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTH
  // A clipped centre is never reported valid.
  a_clip_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[33] && out_tdata[32]))
    else $error("clipped result marked valid");

  // The window never holds more than its largest area.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[42:34] <= 9'd289))
    else $error("window count beyond window area");

  // No window read is in flight while requests are taken.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !sts.pipe_busy)
    else $error("reads in flight while idle");
`endif

endmodule

/* hdl/wsc_divider.sv */
// ----------------------------------------------------------------------------
// wsc_divider: unsigned restoring divider
// One quotient bit per cycle over a fixed number of steps; the quotient and
// a flag for a non-zero remainder stay valid until the next start.
// ----------------------------------------------------------------------------
module wsc_divider
  import wsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output logic             rem_nz,
  output logic             done
);

  localparam int STEP_W = $clog2(DIV_W);

  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]  dsr_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W+1:0]  trial;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial    = {rem_r, quo_r[DIV_W-1]};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      step_nxt = STEP_W'(DIV_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {2'b00, dsr_r}) begin
        rem_nxt = (CNT_W+1)'(trial - {2'b00, dsr_r});
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CNT_W:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign quotient = quo_r;
  assign rem_nz   = (rem_r != '0);
  assign done     = done_r;

endmodule

/* hdl/wsc_sqrt.sv */
// ----------------------------------------------------------------------------
// wsc_sqrt: integer square root
// Digit by digit, two radicand bits per cycle; the root stays valid until
// the next start.
// ----------------------------------------------------------------------------
module wsc_sqrt
  import wsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  localparam int STEP_W = $clog2(ROOT_W);
  localparam int REM_W  = ROOT_W + 3;

  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [REM_W-1:0]  shifted;
  logic [REM_W-1:0]  trial;

  // One digit: bring down two bits and compare with the trial value.
  always_comb begin
    shifted  = {rem_r[REM_W-3:0], rad_r[RAD_W-1:RAD_W-2]};
    trial    = REM_W'({root_r, 2'b01});
    rad_nxt  = rad_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      root_nxt = '0;
      rem_nxt  = '0;
      step_nxt = STEP_W'(ROOT_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt  = shifted - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = shifted;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
  end

  assign root = root_r;
  assign done = done_r;

endmodule

/* hdl/wsc_datapath.sv */
// ----------------------------------------------------------------------------
// wsc_datapath: store, window scanner and statistics of the clip unit
// Holds the pixel memory, the configuration registers, the accumulators,
// the shared divider, the root unit and the result register.
// ----------------------------------------------------------------------------
module wsc_datapath
  import wsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  wsc_cmd_t              cmd,
  output wsc_sts_t              sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // Input fields.
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic [PIX_W-1:0] in_value;
  logic             in_ok;

  assign in_row   = in_tdata[ROW_W-1:0];
  assign in_col   = in_tdata[ROW_W+COL_W-1:ROW_W];
  assign in_value = in_tdata[ROW_W+COL_W+PIX_W-1:ROW_W+COL_W];
  assign in_ok    = in_tdata[ROW_W+COL_W+PIX_W];

  // Configuration registers.
  logic [FRAME_W-1:0] frame_rows_r, frame_cols_r;
  logic [HALF_W-1:0]  half_rows_r, half_cols_r;
  logic [SIGMA_W-1:0] clip_sigma_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rows_r <= FRAME_W'(MAX_ROWS);
      frame_cols_r <= FRAME_W'(MAX_COLS);
      half_rows_r  <= HALF_W'(1);
      half_cols_r  <= HALF_W'(1);
      clip_sigma_r <= SIGMA_W'(768);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FRAME_ROWS: frame_rows_r <= cfg_data[FRAME_W-1:0];
        CFG_FRAME_COLS: frame_cols_r <= cfg_data[FRAME_W-1:0];
        CFG_HALF_ROWS:  half_rows_r  <= cfg_data[HALF_W-1:0];
        CFG_HALF_COLS:  half_cols_r  <= cfg_data[HALF_W-1:0];
        CFG_CLIP_SIGMA: clip_sigma_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective frame and window sizes, saturated to the store.
  logic [FRAME_W-1:0] rows_eff, cols_eff;
  logic [HALF_W-1:0]  hr_eff, hc_eff;

  always_comb begin
    rows_eff = frame_rows_r;
    if (frame_rows_r == '0) rows_eff = FRAME_W'(1);
    else if (frame_rows_r > FRAME_W'(MAX_ROWS)) rows_eff = FRAME_W'(MAX_ROWS);
    cols_eff = frame_cols_r;
    if (frame_cols_r == '0) cols_eff = FRAME_W'(1);
    else if (frame_cols_r > FRAME_W'(MAX_COLS)) cols_eff = FRAME_W'(MAX_COLS);
    hr_eff = (half_rows_r > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : half_rows_r;
    hc_eff = (half_cols_r > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : half_cols_r;
  end

  assign sts.q_in_range = ({1'b0, in_row} < rows_eff) && ({1'b0, in_col} < cols_eff);

  // Latched query address and window bounds.
  logic [ROW_W-1:0] row_r, rb, re;
  logic [COL_W-1:0] col_r, cb, ce;
  logic [ROW_W:0]   row_hi;
  logic [COL_W:0]   col_hi;
  logic [FRAME_W-1:0] rows_m1, cols_m1;

  always_ff @(posedge clk) begin
    if (cmd.q_latch) begin
      row_r <= in_row;
      col_r <= in_col;
    end
  end

  always_comb begin
    row_hi  = {1'b0, row_r} + (ROW_W+1)'(hr_eff);
    col_hi  = {1'b0, col_r} + (COL_W+1)'(hc_eff);
    rows_m1 = rows_eff - 1'b1;
    cols_m1 = cols_eff - 1'b1;
    rb = (row_r >= ROW_W'(hr_eff)) ? row_r - ROW_W'(hr_eff) : '0;
    cb = (col_r >= COL_W'(hc_eff)) ? col_r - COL_W'(hc_eff) : '0;
    re = (FRAME_W'(row_hi) < rows_eff) ? row_hi[ROW_W-1:0] : rows_m1[ROW_W-1:0];
    ce = (FRAME_W'(col_hi) < cols_eff) ? col_hi[COL_W-1:0] : cols_m1[COL_W-1:0];
  end

  // Window scanner: row by row, inclusive bounds.
  logic [ROW_W-1:0] scan_r_r;
  logic [COL_W-1:0] scan_c_r;

  always_ff @(posedge clk) begin
    if (cmd.scan_load) begin
      scan_r_r <= rb;
      scan_c_r <= cb;
    end else if (cmd.scan_rd) begin
      if (scan_c_r == ce) begin
        scan_c_r <= cb;
        scan_r_r <= scan_r_r + 1'b1;
      end else begin
        scan_c_r <= scan_c_r + 1'b1;
      end
    end
  end

  assign sts.scan_last = (scan_r_r == re) && (scan_c_r == ce);

  // Pixel memory, one write and one registered read.
  logic [ENTRY_W-1:0] mem [0:MAX_ROWS*MAX_COLS-1];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_en;

  assign rd_en   = cmd.centre_rd | cmd.scan_rd;
  assign rd_addr = cmd.centre_rd ? {row_r, col_r} : {scan_r_r, scan_c_r};

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[{in_row, in_col}] <= {in_ok, in_value};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Tags of reads in flight.
  logic rd_vld_r, rd_cent_r, rd_p2_r;
  logic sq_vld_r, prod_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      sq_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= rd_en;
      sq_vld_r   <= rd_vld_r & rd_p2_r & ~rd_cent_r & rd_data_r[PIX_W];
      prod_vld_r <= sq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_cent_r <= cmd.centre_rd;
    rd_p2_r   <= cmd.pass2;
  end

  assign sts.pipe_busy = rd_vld_r | sq_vld_r | prod_vld_r;

  // Centre sample and first pass: count and sum.
  logic signed [PIX_W-1:0] centre_r;
  logic                    cvalid_r;
  logic [CNT_W-1:0]        n_r;
  logic signed [SUM_W-1:0] sum_r;
  logic                    rd_acc1;

  assign rd_acc1 = rd_vld_r & ~rd_cent_r & ~rd_p2_r & rd_data_r[PIX_W];

  always_ff @(posedge clk) begin
    if (rd_vld_r && rd_cent_r) begin
      centre_r <= rd_data_r[PIX_W-1:0];
      cvalid_r <= rd_data_r[PIX_W];
    end
    if (cmd.clr_acc) begin
      n_r   <= '0;
      sum_r <= '0;
    end else if (rd_acc1) begin
      n_r   <= n_r + 1'b1;
      sum_r <= sum_r + SUM_W'($signed(rd_data_r[PIX_W-1:0]));
    end
  end

  assign sts.stats_ok = (n_r >= CNT_W'(2)) && cvalid_r;

  // Shared divider.
  logic [SUMSQ_W-1:0] sumsq_r;
  logic [SUM_W-1:0]   sum_mag;
  logic [DIV_W-1:0]   div_dividend, div_quo;
  logic [CNT_W-1:0]   div_divisor;
  logic               div_rem_nz;

  assign sum_mag      = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign div_dividend = cmd.div_sel ? DIV_W'(sumsq_r) : DIV_W'(sum_mag);
  assign div_divisor  = cmd.div_sel ? n_r - 1'b1 : n_r;

  wsc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .rem_nz   (div_rem_nz),
    .done     (sts.div_done)
  );

  // Mean, rounded towards minus infinity.
  logic signed [PIX_W-1:0] mean_r;
  logic [PIX_W:0]          mean_mag;

  assign mean_mag = {1'b0, div_quo[PIX_W-1:0]} + (PIX_W+1)'(sum_r[SUM_W-1] & div_rem_nz);

  always_ff @(posedge clk) begin
    if (cmd.mean_cap) begin
      mean_r <= sum_r[SUM_W-1] ? PIX_W'(-mean_mag) : mean_mag[PIX_W-1:0];
    end
  end

  // Second pass: absolute deviation, square, then accumulate.
  logic signed [PIX_W:0] diff;
  logic [PIX_W-1:0]      ad_r;
  logic [2*PIX_W-1:0]    prod_r;

  assign diff = $signed({rd_data_r[PIX_W-1], rd_data_r[PIX_W-1:0]})
              - $signed({mean_r[PIX_W-1], mean_r});

  always_ff @(posedge clk) begin
    ad_r   <= diff[PIX_W] ? PIX_W'(-diff) : diff[PIX_W-1:0];
    prod_r <= ad_r * ad_r;
    if (cmd.scan_load) begin
      sumsq_r <= '0;
    end else if (prod_vld_r) begin
      sumsq_r <= sumsq_r + SUMSQ_W'(prod_r[2*PIX_W-1:16]);
    end
  end

  // Root of the variance in Q16.16.
  logic [ROOT_W-1:0] sd;

  wsc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand ({1'b0, div_quo, 16'b0}),
    .root     (sd),
    .done     (sts.sqrt_done)
  );

  // Threshold and decision.
  logic [THR_W-1:0]         t_r;
  logic signed [THR_W-7:0]  thr;
  logic                     clipped_r;

  assign thr = $signed((THR_W-6)'(mean_r)) + $signed({2'b00, t_r[THR_W-1:8]});

  always_ff @(posedge clk) begin
    if (cmd.thr_cap) begin
      t_r <= clip_sigma_r * sd;
    end
    if (cmd.clr_acc) begin
      clipped_r <= 1'b0;
    end else if (cmd.dec_cap) begin
      clipped_r <= $signed((THR_W-6)'(centre_r)) > thr;
    end
  end

  // Result register.
  logic out_full_r;

  assign sts.slot_free = ~out_full_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_full_r <= 1'b0;
    end else begin
      out_full_r <= cmd.res_load | (out_full_r & ~out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_tdata <= {5'b0, n_r, clipped_r, cvalid_r & ~clipped_r, centre_r};
    end
  end

  assign out_tvalid = out_full_r;

endmodule

/* hdl/wsc_ctrl.sv */
// ----------------------------------------------------------------------------
// wsc_ctrl: request sequencer of the clip unit
// Takes requests, drives the two window passes, the divides, the root and
// the decision, and hands the result to the output register.
// ----------------------------------------------------------------------------
module wsc_ctrl
  import wsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  logic     in_tuser,
  input  wsc_sts_t sts,
  output wsc_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_SCAN1,
    ST_DRAIN1,
    ST_DIV1,
    ST_SCAN2,
    ST_DRAIN2,
    ST_DIV2,
    ST_ROOT,
    ST_THR,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid & in_tready;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == ACT_WRITE) begin
            cmd.wr_en = 1'b1;
          end else if (sts.q_in_range) begin
            cmd.q_latch = 1'b1;
            state_nxt   = ST_CENTRE;
          end
        end
      end
      ST_CENTRE: begin
        cmd.centre_rd = 1'b1;
        cmd.scan_load = 1'b1;
        cmd.clr_acc   = 1'b1;
        state_nxt     = ST_SCAN1;
      end
      ST_SCAN1: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) state_nxt = ST_DRAIN1;
      end
      ST_DRAIN1: begin
        if (!sts.pipe_busy) begin
          if (sts.stats_ok) begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIV1;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_DIV1: begin
        if (sts.div_done) begin
          cmd.mean_cap  = 1'b1;
          cmd.scan_load = 1'b1;
          state_nxt     = ST_SCAN2;
        end
      end
      ST_SCAN2: begin
        cmd.scan_rd = 1'b1;
        cmd.pass2   = 1'b1;
        if (sts.scan_last) state_nxt = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        if (!sts.pipe_busy) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_nxt     = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (sts.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sts.sqrt_done) begin
          cmd.thr_cap = 1'b1;
          state_nxt   = ST_THR;
        end
      end
      ST_THR: begin
        cmd.dec_cap = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (sts.slot_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
